// ----- hw/rtl/rht_pkg.sv -----
package rht_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned REFS_W    = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CAP_W     = 5;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_WRITE    = 2'd2;
  localparam logic [1:0] OP_REASSIGN = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [REFS_W-1:0] refs;
    logic [DATA_W-1:0] data;
  } slot_t;

endpackage

// ----- hw/rtl/rht_ram.sv -----
module rht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/refcounted_handle_table.sv -----
// Compacting table of reference-counted handles, each slot owning one 32-bit word.
// Issue a command by raising start while busy is low; busy then stays high until the
// result has been produced, except for allocate, which never raises busy. Every
// command returns exactly one result, shown on status_o/new_handle_o/read_value_o
// for the single cycle in which done_o is high; the receiver cannot stall it, so
// capture it in that cycle. Allocate's result shows in the cycle after its command
// beat. Read and write scan the slots in order through one slot RAM read port,
// reading each slot and then comparing it. Reassign runs two such scans back to
// back, and when a count drops to zero it compacts the table, copying each trailing
// slot down one place. The capacity register is written on its own valid/ready
// channel, taken whenever the block is idle. Slot contents are not cleared at reset;
// the slot count, the id counter and the capacity register are.
module refcounted_handle_table #(
  parameter int unsigned Slots = rht_pkg::SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command beat
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op_i,
  input  logic [rht_pkg::ID_W-1:0]    handle_i,
  input  logic [rht_pkg::ID_W-1:0]    other_handle_i,
  input  logic signed [rht_pkg::DATA_W-1:0] value_i,
  // result beat
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [rht_pkg::ID_W-1:0]    new_handle_o,
  output logic signed [rht_pkg::DATA_W-1:0] read_value_o,
  // capacity register
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rht_pkg::CAP_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);
  localparam int unsigned MW = (CW + 1 > rht_pkg::CAP_W) ? CW + 1 : rht_pkg::CAP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHF_RD,
    S_SHF_WR
  } state_e;

  state_e                       state_q;
  logic [CW-1:0]                count_q;
  logic [CW-1:0]                idx_q;
  logic [rht_pkg::ID_W-1:0]     last_id_q;
  logic [rht_pkg::CAP_W-1:0]    cap_q;
  logic                         second_q;
  logic [1:0]                   op_q;
  logic [rht_pkg::ID_W-1:0]     h_q;
  logic [rht_pkg::ID_W-1:0]     oh_q;
  logic [rht_pkg::DATA_W-1:0]   val_q;
  logic                         done_q;
  logic [1:0]                   status_q;
  logic [rht_pkg::ID_W-1:0]     nh_q;
  logic [rht_pkg::DATA_W-1:0]   rv_q;

  rht_pkg::slot_t               rdata;
  rht_pkg::slot_t               wdata;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                raddr;
  logic [CW-1:0]                idx_nx;
  logic [rht_pkg::ID_W-1:0]     target;
  logic                         hit;
  logic                         full;
  logic                         accept;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  assign idx_nx = idx_q + CW'(1);
  // The first scan of a reassign looks for the id gaining a reference.
  assign target = (op_q == rht_pkg::OP_REASSIGN && !second_q) ? oh_q : h_q;
  assign hit    = (rdata.id == target);
  assign full   = (count_q >= CW'(Slots)) ||
                  (MW'(cap_q) <= MW'(count_q) + MW'(1));
  // Compaction reads one slot ahead of the one being rewritten.
  assign raddr  = (state_q == S_SHF_RD) ? idx_nx[AW-1:0] : idx_q[AW-1:0];

  // Slot RAM write port.
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op_i == rht_pkg::OP_ALLOC) begin
          wdata.refs = rht_pkg::REFS_W'(1);
          wdata.data = '0;
          if (count_q == '0) begin
            we       = 1'b1;
            waddr    = '0;
            wdata.id = rht_pkg::ID_W'(1);
          end else if (!full) begin
            we       = 1'b1;
            waddr    = count_q[AW-1:0];
            wdata.id = last_id_q + rht_pkg::ID_W'(1);
          end
        end
      end
      S_SRCH_CMP: begin
        if (hit) begin
          if (op_q == rht_pkg::OP_WRITE) begin
            we         = 1'b1;
            wdata.data = val_q;
          end else if (op_q == rht_pkg::OP_REASSIGN && !second_q) begin
            // saturate the added reference
            we         = (rdata.refs != '1);
            wdata.refs = rdata.refs + rht_pkg::REFS_W'(1);
          end else if (op_q == rht_pkg::OP_REASSIGN) begin
            we         = (rdata.refs > rht_pkg::REFS_W'(1));
            wdata.refs = rdata.refs - rht_pkg::REFS_W'(1);
          end
        end
      end
      S_SHF_WR: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  rht_ram #(
    .Width ($bits(rht_pkg::slot_t)),
    .Depth (Slots)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      last_id_q <= '0;
      cap_q     <= '0;
      second_q  <= 1'b0;
      done_q    <= 1'b0;
      status_q  <= rht_pkg::ST_OK;
      nh_q      <= '0;
      rv_q      <= '0;
      op_q      <= rht_pkg::OP_ALLOC;
      h_q       <= '0;
      oh_q      <= '0;
      val_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op_i;
            h_q      <= handle_i;
            oh_q     <= other_handle_i;
            val_q    <= value_i;
            idx_q    <= '0;
            second_q <= 1'b0;
            status_q <= rht_pkg::ST_OK;
            nh_q     <= '0;
            rv_q     <= '0;
            if (op_i == rht_pkg::OP_ALLOC) begin
              // allocate completes here
              done_q <= 1'b1;
              if (count_q == '0) begin
                count_q   <= CW'(1);
                last_id_q <= rht_pkg::ID_W'(1);
                nh_q      <= rht_pkg::ID_W'(1);
              end else if (full) begin
                status_q <= rht_pkg::ST_FULL;
              end else begin
                count_q   <= count_q + CW'(1);
                last_id_q <= last_id_q + rht_pkg::ID_W'(1);
                nh_q      <= last_id_q + rht_pkg::ID_W'(1);
              end
            end else begin
              state_q <= S_SRCH_RD;
            end
          end
        end
        S_SRCH_RD: begin
          if (idx_q >= count_q) begin
            if (op_q == rht_pkg::OP_REASSIGN && !second_q) begin
              // absent id gaining a reference: skip to the drop
              second_q <= 1'b1;
              idx_q    <= '0;
            end else begin
              status_q <= rht_pkg::ST_NOT_FOUND;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end
          end else begin
            state_q <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (!hit) begin
            idx_q   <= idx_nx;
            state_q <= S_SRCH_RD;
          end else if (op_q == rht_pkg::OP_READ) begin
            rv_q    <= rdata.data;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (op_q == rht_pkg::OP_WRITE) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (!second_q) begin
            second_q <= 1'b1;
            idx_q    <= '0;
            state_q  <= S_SRCH_RD;
          end else if (rdata.refs <= rht_pkg::REFS_W'(1)) begin
            // last reference gone: compact from this slot
            state_q <= S_SHF_RD;
          end else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_SHF_RD: begin
          if (idx_nx >= count_q) begin
            count_q <= count_q - CW'(1);
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SHF_WR;
          end
        end
        S_SHF_WR: begin
          idx_q   <= idx_nx;
          state_q <= S_SHF_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign new_handle_o = nh_q;
  assign read_value_o = rv_q;

endmodule

// ----- test/tb_refcounted_handle_table.sv -----
`timescale 1ns / 1ps

module tb_refcounted_handle_table;
  import rht_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  // Two copies of the table model: one advanced while the stimulus is planned,
  // one advanced as the block really takes each command beat.
  localparam int PLAN       = 0;
  localparam int LIVE       = 1;
  // Settle well past the slowest command at the end.
  localparam int SETTLE     = 8 * SLOTS;
  localparam int MAX_PRINTS = 40;
  localparam int RAND_ITEMS = 1300;

  typedef enum logic [1:0] {
    BEAT_CMD,
    BEAT_CFG,
    BEAT_DRAIN
  } beat_kind_e;

  typedef struct packed {
    beat_kind_e        kind;
    logic [1:0]        op;
    logic [ID_W-1:0]   handle;
    logic [ID_W-1:0]   other;
    logic [DATA_W-1:0] value;
    logic [CAP_W-1:0]  cap;
    logic [6:0]        idle_pct;
  } beat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   new_handle;
    logic [DATA_W-1:0] read_value;
  } outcome_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     start          = 1'b0;
  logic                     busy;
  logic [1:0]               op_i           = OP_ALLOC;
  logic [ID_W-1:0]          handle_i       = '0;
  logic [ID_W-1:0]          other_handle_i = '0;
  logic signed [DATA_W-1:0] value_i        = '0;
  logic                     done_o;
  logic [1:0]               status_o;
  logic [ID_W-1:0]          new_handle_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [CAP_W-1:0]         cfg_data_i     = '0;

  refcounted_handle_table #(
    .Slots(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .handle_i      (handle_i),
    .other_handle_i(other_handle_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .new_handle_o  (new_handle_o),
    .read_value_o  (read_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Hold reset low at the start, then release it for good.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Table model state, one copy per view.
  logic [ID_W-1:0]   tbl_id    [2][SLOTS];
  logic [REFS_W-1:0] tbl_refs  [2][SLOTS];
  logic [DATA_W-1:0] tbl_data  [2][SLOTS];
  bit                tbl_wrote [2][SLOTS];
  int unsigned       tbl_count [2];
  logic [ID_W-1:0]   tbl_last  [2];
  logic [CAP_W-1:0]  tbl_cap   [2];

  beat_t    cmd_backlog[$];      // beats still to be driven
  outcome_t awaited_results[$];  // predicted results, oldest first

  int results_due = 0;           // commands taken minus results seen
  int mismatches  = 0;
  int cfg_writes  = 0;
  int op_count     [4] = '{default: 0};
  int status_count [4] = '{default: 0};

  // Lowest slot holding the id, or SLOTS when there is none.
  function automatic int find_handle(int s, logic [ID_W-1:0] id);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (i < tbl_count[s] && tbl_id[s][i] == id) return i;
    end
    return SLOTS;
  endfunction

  // Advance one copy of the table by one command and return its result.
  function automatic outcome_t table_apply(int s, beat_t b);
    outcome_t r;
    int p;
    int q;
    r = '0;
    r.status = ST_OK;
    case (b.op)
      OP_ALLOC: begin
        if (tbl_count[s] == 0) begin
          // Empty table: always taken, ids restart at 1.
          tbl_id[s][0]    = 16'd1;
          tbl_refs[s][0]  = 16'd1;
          tbl_data[s][0]  = '0;
          tbl_wrote[s][0] = 1'b0;
          tbl_last[s]     = 16'd1;
          tbl_count[s]    = 1;
          r.new_handle    = 16'd1;
        end else if (tbl_count[s] >= SLOTS || tbl_cap[s] <= tbl_count[s] + 1) begin
          r.status = ST_FULL;
        end else begin
          tbl_last[s]     = tbl_last[s] + 1'b1;
          p               = tbl_count[s];
          tbl_id[s][p]    = tbl_last[s];
          tbl_refs[s][p]  = 16'd1;
          tbl_data[s][p]  = '0;
          tbl_wrote[s][p] = 1'b0;
          tbl_count[s]    = tbl_count[s] + 1;
          r.new_handle    = tbl_last[s];
        end
      end
      OP_READ: begin
        p = find_handle(s, b.handle);
        if (p == SLOTS) r.status = ST_NOT_FOUND;
        else r.read_value = tbl_data[s][p];
      end
      OP_WRITE: begin
        p = find_handle(s, b.handle);
        if (p == SLOTS) begin
          r.status = ST_NOT_FOUND;
        end else begin
          tbl_data[s][p]  = b.value;
          tbl_wrote[s][p] = 1'b1;
        end
      end
      default: begin
        // Gain first (saturating, absent id ignored), then drop.
        p = find_handle(s, b.other);
        if (p < SLOTS && tbl_refs[s][p] != '1) tbl_refs[s][p] = tbl_refs[s][p] + 1'b1;
        p = find_handle(s, b.handle);
        if (p == SLOTS) begin
          r.status = ST_NOT_FOUND;
        end else if (tbl_refs[s][p] <= 1) begin
          // Last reference gone: close the gap by shifting the tail down.
          for (q = p; q + 1 < tbl_count[s]; q++) begin
            tbl_id[s][q]    = tbl_id[s][q+1];
            tbl_refs[s][q]  = tbl_refs[s][q+1];
            tbl_data[s][q]  = tbl_data[s][q+1];
            tbl_wrote[s][q] = tbl_wrote[s][q+1];
          end
          tbl_count[s] = tbl_count[s] - 1;
        end else begin
          tbl_refs[s][p] = tbl_refs[s][p] - 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Queue one command and advance the planning copy with it.
  function automatic void plan_cmd(logic [1:0] op, logic [ID_W-1:0] h,
                                   logic [ID_W-1:0] oh, logic [DATA_W-1:0] v, int pct);
    beat_t b;
    int p;
    // Never read a word that was never stored: store to it instead.
    if (op == OP_READ) begin
      p = find_handle(PLAN, h);
      if (p < SLOTS && !tbl_wrote[PLAN][p]) op = OP_WRITE;
    end
    b          = '0;
    b.kind     = BEAT_CMD;
    b.op       = op;
    b.handle   = h;
    b.other    = oh;
    b.value    = v;
    b.idle_pct = 7'(pct);
    void'(table_apply(PLAN, b));
    cmd_backlog = {cmd_backlog, b};
  endfunction

  function automatic void plan_cfg(logic [CAP_W-1:0] cap);
    beat_t b;
    b             = '0;
    b.kind        = BEAT_CFG;
    b.cap         = cap;
    tbl_cap[PLAN] = cap;
    cmd_backlog   = {cmd_backlog, b};
  endfunction

  function automatic void plan_drain();
    beat_t b;
    b           = '0;
    b.kind      = BEAT_DRAIN;
    cmd_backlog = {cmd_backlog, b};
  endfunction

  // Mostly a live id, otherwise an edge value or a random (likely absent) one.
  function automatic logic [ID_W-1:0] pick_handle();
    if (tbl_count[PLAN] != 0 && $urandom_range(99) < 75)
      return tbl_id[PLAN][$urandom_range(tbl_count[PLAN] - 1)];
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return tbl_last[PLAN] + 1'b1;
      default: return ID_W'($urandom);
    endcase
  endfunction

  function automatic logic [ID_W-1:0] absent_handle();
    logic [ID_W-1:0] c;
    c = ID_W'($urandom);
    while (find_handle(PLAN, c) != SLOTS) c = ID_W'($urandom);
    return c;
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 5'd1;
      2:       return 5'd2;
      3:       return CAP_W'(SLOTS);
      4:       return CAP_W'(SLOTS + 1);
      5:       return '1;
      default: return CAP_W'($urandom_range(3, SLOTS));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Driver: retire the beat taken at this edge, then present the next one.
  // Commands are predicted on the live copy at the edge that takes them.
  always @(posedge clk_i) begin : driver
    beat_t b;
    logic  hold_cmd;
    logic  hold_cfg;
    if (rst_ni) begin
      if (done_o) results_due--;
      hold_cmd = start && busy;
      hold_cfg = cfg_valid_i && !cfg_ready_o;
      if (start && !busy) begin
        b        = '0;
        b.op     = op_i;
        b.handle = handle_i;
        b.other  = other_handle_i;
        b.value  = value_i;
        awaited_results = {awaited_results, table_apply(LIVE, b)};
        results_due++;
        op_count[op_i]++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        tbl_cap[LIVE] = cfg_data_i;
        cfg_writes++;
      end
      if (!hold_cmd && !hold_cfg) begin
        if (cmd_backlog.size() == 0) begin
          start       <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else begin
          b = cmd_backlog[0];
          case (b.kind)
            BEAT_CMD: begin
              cfg_valid_i <= 1'b0;
              // Drop start for a cycle now and then to put gaps between beats.
              if ($urandom_range(99) < b.idle_pct) begin
                start <= 1'b0;
              end else begin
                start          <= 1'b1;
                op_i           <= b.op;
                handle_i       <= b.handle;
                other_handle_i <= b.other;
                value_i        <= b.value;
                void'(cmd_backlog.pop_front());
              end
            end
            BEAT_CFG: begin
              // Write capacity only with the block idle and nothing outstanding.
              start <= 1'b0;
              if (results_due == 0 && !busy) begin
                cfg_valid_i <= 1'b1;
                cfg_data_i  <= b.cap;
                void'(cmd_backlog.pop_front());
              end else begin
                cfg_valid_i <= 1'b0;
              end
            end
            default: begin
              // Hold off until every outstanding result is back.
              start       <= 1'b0;
              cfg_valid_i <= 1'b0;
              if (results_due == 0 && !busy) void'(cmd_backlog.pop_front());
            end
          endcase
        end
      end
    end
  end

  // Monitor: a result lives for one cycle only, so take it at the edge ending it.
  always @(posedge clk_i) begin : monitor
    outcome_t want;
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no command outstanding", DATA_W'(status_o), '0);
      end else begin
        want = awaited_results.pop_front();
        status_count[want.status]++;
        if (status_o !== want.status)
          report_mismatch("status", DATA_W'(status_o), DATA_W'(want.status));
        if (new_handle_o !== want.new_handle)
          report_mismatch("new_handle", DATA_W'(new_handle_o), DATA_W'(want.new_handle));
        if (read_value_o !== want.read_value)
          report_mismatch("read_value", read_value_o, want.read_value);
      end
    end
  end

  initial begin : stimulus
    int               s;
    int               k;
    int               phase;
    int               pct;
    int               sel;
    logic [ID_W-1:0]  h;

    for (s = 0; s < 2; s++) begin
      tbl_count[s] = 0;
      tbl_last[s]  = '0;
      tbl_cap[s]   = '0;
    end

    // Directed part, capacity still at its reset value of zero.
    plan_cmd(OP_READ, '1, '0, '0, 0);                // empty table: miss
    plan_cmd(OP_ALLOC, '0, '0, '0, 0);               // first slot ignores capacity
    plan_cmd(OP_ALLOC, '0, '0, '0, 0);               // refused by capacity
    plan_cmd(OP_WRITE, 16'd1, '0, 32'h8000_0000, 0);
    plan_cmd(OP_READ, 16'd1, '0, '0, 0);
    plan_cmd(OP_REASSIGN, 16'd1, 16'd1, '0, 0);      // same id twice: no change
    plan_cmd(OP_REASSIGN, '1, 16'd1, '0, 0);         // absent drop, gain stays
    plan_cmd(OP_REASSIGN, 16'd1, '0, '0, 0);         // absent gain ignored
    plan_cmd(OP_REASSIGN, 16'd1, '0, '0, 0);         // last slot removed
    plan_cmd(OP_ALLOC, '0, '0, '0, 0);               // ids restart at 1
    plan_cfg('1);
    for (k = 0; k < SLOTS; k++) plan_cmd(OP_ALLOC, '1, '1, '1, 0);  // fill, then hit the wall
    plan_cmd(OP_WRITE, ID_W'(SLOTS), '0, 32'h7FFF_FFFF, 0);
    plan_cmd(OP_READ, ID_W'(SLOTS), '0, '0, 0);
    plan_cmd(OP_REASSIGN, 16'd1, '0, '0, 0);         // drop the head, shift all

    // Random part in three idling regimes: light gaps, heavy gaps, none.
    for (phase = 0; phase < 3; phase++) begin
      pct = (phase == 0) ? 14 : (phase == 1) ? 48 : 0;
      plan_drain();
      plan_cfg(pick_capacity());
      for (k = 0; k < RAND_ITEMS / 3; k++) begin
        if ($urandom_range(69) == 0) plan_cfg(pick_capacity());
        if ($urandom_range(89) == 0) plan_drain();
        sel = $urandom_range(99);
        if (sel < 28) begin
          plan_cmd(OP_ALLOC, ID_W'($urandom), ID_W'($urandom), $urandom, pct);
        end else if (sel < 50) begin
          plan_cmd(OP_READ, pick_handle(), ID_W'($urandom), $urandom, pct);
        end else if (sel < 74) begin
          plan_cmd(OP_WRITE, pick_handle(), ID_W'($urandom), $urandom, pct);
        end else begin
          h = pick_handle();
          plan_cmd(OP_REASSIGN, h, ($urandom_range(9) == 0) ? h : pick_handle(),
                   $urandom, pct);
        end
      end
    end

    // Tail: empty the table through its head slot, then start over and
    // work the restarted ids once more.
    plan_cfg(CAP_W'(SLOTS));
    while (tbl_count[PLAN] != 0)
      plan_cmd(OP_REASSIGN, tbl_id[PLAN][0], absent_handle(), $urandom, 0);
    plan_cmd(OP_ALLOC, '0, '0, '0, 0);
    plan_cmd(OP_WRITE, 16'd1, '0, 32'h5A5A_A5A5, 0);
    plan_cmd(OP_ALLOC, '0, '0, '0, 0);
    plan_cmd(OP_READ, 16'd1, '0, '0, 0);
    plan_cmd(OP_REASSIGN, absent_handle(), 16'd1, '0, 0);
    plan_cmd(OP_WRITE, 16'd1, '0, 32'hFFFF_FFFF, 0);
    plan_cmd(OP_READ, 16'd1, '0, '0, 0);
    plan_cmd(OP_REASSIGN, 16'd1, 16'd1, '0, 0);
    plan_cmd(OP_READ, 16'd1, '0, '0, 0);

    // Wait on the falling edge so every update of the rising edge is in.
    @(posedge rst_ni);
    while (cmd_backlog.size() != 0 || start || cfg_valid_i || results_due > 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("results never returned", DATA_W'(awaited_results.size()), '0);

    $display("run covered %0d allocates, %0d reads, %0d writes, %0d reassigns, %0d capacity writes",
             op_count[OP_ALLOC], op_count[OP_READ], op_count[OP_WRITE],
             op_count[OP_REASSIGN], cfg_writes);
    $display("outcomes: %0d ok, %0d id not found, %0d table full, %0d mismatches",
             status_count[ST_OK], status_count[ST_NOT_FOUND], status_count[ST_FULL],
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("timeout: the table stopped answering");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
